// ===== hdl/apl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package apl_pkg;

   localparam int SAMPLE_W = 12;
   localparam int LEVEL_W = 6;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_INDEX_W = 1;

   localparam logic [SAMPLE_W-1:0] NOISE_FLOOR_RST = 12'd150;
   localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 12'd2500;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd4095;
   localparam int MAX_LEVEL_DEF = 40;

   localparam logic [CSR_INDEX_W-1:0] REG_NOISE_FLOOR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_FULL_SCALE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic sample_take;
      logic window_close;
      logic setup;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ===== hdl/apl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apl_ctrl #(
   parameter int DIV_STEPS = 18
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   input  wire logic               req_tlast,
   output logic                    req_tready,
   input  wire apl_pkg::stat_type  stat,
   output apl_pkg::cmd_type        cmd
);

   localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

   apl_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic accept;

   assign accept = req_tvalid && (state_ff == apl_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apl_pkg::ST_IDLE: begin
            if (accept && req_tlast) state_in = apl_pkg::ST_SETUP;
         end
         apl_pkg::ST_SETUP: begin
            state_in = apl_pkg::ST_DIVIDE;
         end
         apl_pkg::ST_DIVIDE: begin
            if (cnt_ff == CNT_LAST) state_in = apl_pkg::ST_FINISH;
         end
         apl_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = apl_pkg::ST_IDLE;
         end
         default: state_in = apl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd = '0;
      cnt_in = cnt_ff;
      unique case (state_ff)
         apl_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.sample_take = accept;
            cmd.window_close = accept && req_tlast;
         end
         apl_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            cnt_in = '0;
         end
         apl_pkg::ST_DIVIDE: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
         end
         apl_pkg::ST_FINISH: begin
            cmd.finish = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apl_pkg::ST_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/apl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module apl_datapath #(
   parameter int MAX_LEVEL = apl_pkg::MAX_LEVEL_DEF,
   parameter int NUM_W = apl_pkg::SAMPLE_W + $clog2(MAX_LEVEL + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [apl_pkg::SAMPLE_W-1:0]        sample,
   input  wire logic                                csr_valid,
   input  wire logic [apl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [apl_pkg::SAMPLE_W-1:0]        csr_data,
   input  wire apl_pkg::cmd_type                    cmd,
   output apl_pkg::stat_type                        stat,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [apl_pkg::LEVEL_W-1:0]              level
);

   localparam int SW = apl_pkg::SAMPLE_W;
   localparam int LW = apl_pkg::LEVEL_W;
   localparam logic [LW-1:0] MAX_LVL = LW'(MAX_LEVEL);

   logic [SW-1:0] noise_floor_ff, full_scale_ff;
   logic [SW-1:0] max_ff, min_ff, max_in, min_in;
   logic [SW-1:0] win_max_ff, win_min_ff;
   logic [SW-1:0] den_ff, rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic direct_ff;
   logic [LW-1:0] direct_lvl_ff;
   logic [LW-1:0] held_ff, held_in;
   logic [LW-1:0] level_ff;
   logic rsp_valid_ff;

   logic [SW-1:0] swing, swing_f;
   logic step_mode, direct;
   logic [LW-1:0] direct_lvl;
   logic [NUM_W-1:0] num;
   logic [SW:0] rem_sh, rem_diff;
   logic [LW-1:0] lvl;

   assign max_in = (sample > max_ff) ? sample : max_ff;
   assign min_in = (sample < min_ff) ? sample : min_ff;

   always_comb begin
      swing = (win_max_ff >= win_min_ff) ? (win_max_ff - win_min_ff) : '0;
      swing_f = (swing < noise_floor_ff) ? '0 : swing;
      step_mode = (full_scale_ff <= noise_floor_ff);
      direct = step_mode || (swing_f <= noise_floor_ff);
      direct_lvl = (step_mode && (swing_f > noise_floor_ff)) ? MAX_LVL : '0;
      num = NUM_W'(swing_f - noise_floor_ff) * NUM_W'(MAX_LEVEL);
   end

   always_comb begin
      rem_sh = {rem_ff, quo_ff[NUM_W-1]};
      rem_diff = rem_sh - {1'b0, den_ff};
      if (rem_sh >= {1'b0, den_ff}) begin
         rem_in = rem_diff[SW-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh[SW-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_comb begin
      if (direct_ff) lvl = direct_lvl_ff;
      else if (quo_ff > NUM_W'(MAX_LEVEL)) lvl = MAX_LVL;
      else lvl = quo_ff[LW-1:0];
      held_in = (lvl >= held_ff) ? lvl : (held_ff - 1'b1);
   end

   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_floor_ff <= apl_pkg::NOISE_FLOOR_RST;
         full_scale_ff <= apl_pkg::FULL_SCALE_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            apl_pkg::REG_NOISE_FLOOR: noise_floor_ff <= csr_data;
            apl_pkg::REG_FULL_SCALE: full_scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
         min_ff <= apl_pkg::SAMPLE_MAX;
         held_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.window_close) begin
            max_ff <= '0;
            min_ff <= apl_pkg::SAMPLE_MAX;
         end else if (cmd.sample_take) begin
            max_ff <= max_in;
            min_ff <= min_in;
         end
         if (cmd.finish) begin
            held_ff <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.window_close) begin
         win_max_ff <= max_in;
         win_min_ff <= min_in;
      end
      if (cmd.setup) begin
         den_ff <= full_scale_ff - noise_floor_ff;
         rem_ff <= '0;
         quo_ff <= num;
         direct_ff <= direct;
         direct_lvl_ff <= direct_lvl;
      end else if (cmd.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.finish) level_ff <= held_in;
   end

endmodule
`default_nettype wire

// ===== hdl/audio_peak_level_meter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Peak-to-peak level meter. While req_tready is high one sample is taken
// per clock, tracking the running maximum and minimum. The beat with tlast
// closes the window (that sample counts); the swing is then mapped onto
// 0..MAX_LEVEL by a bit-serial restoring divider, and the held level (which
// jumps up at once or drops by one per window) leaves as one rsp beat.
// After a window-end beat req_tready stays low while the one-bit-per-cycle
// divider goes through its setup, divide and finish states, and stays low
// longer if the previous result has not been taken yet. Registers: index 0
// noise_floor (reset 150), index 1 full_scale (reset 2500); write them only
// while no window end is in flight.
module audio_peak_level_meter_unit #(
   parameter int MAX_LEVEL = apl_pkg::MAX_LEVEL_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [apl_pkg::REQ_DATA_W-1:0]       req_tdata,   // [11:0] sample
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   output logic [apl_pkg::RSP_DATA_W-1:0]            rsp_tdata,   // [5:0] level
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [apl_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [apl_pkg::SAMPLE_W-1:0]         csr_data
);

   localparam int NUM_W = apl_pkg::SAMPLE_W + $clog2(MAX_LEVEL + 1);

   apl_pkg::cmd_type cmd;
   apl_pkg::stat_type stat;
   logic [apl_pkg::LEVEL_W-1:0] level;

   assign csr_ready = 1'b1;
   assign rsp_tdata = apl_pkg::RSP_DATA_W'(level);

   apl_ctrl #(
      .DIV_STEPS(NUM_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tlast(req_tlast),
      .req_tready(req_tready),
      .stat(stat),
      .cmd(cmd)
   );

   apl_datapath #(
      .MAX_LEVEL(MAX_LEVEL),
      .NUM_W(NUM_W)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .sample(req_tdata[apl_pkg::SAMPLE_W-1:0]),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .cmd(cmd),
      .stat(stat),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .level(level)
   );

endmodule
`default_nettype wire

// ===== tb/audio_peak_level_meter_unit_tb.sv =====
`timescale 1ns / 1ps
module audio_peak_level_meter_unit_tb;
   import apl_pkg::*;

   localparam int MAX_LEVEL = MAX_LEVEL_DEF;
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 400;

   class level_scoreboard;
      logic [SAMPLE_W-1:0] noise_floor;
      logic [SAMPLE_W-1:0] full_scale;
      logic [SAMPLE_W-1:0] window_max;
      logic [SAMPLE_W-1:0] window_min;
      logic [LEVEL_W-1:0] held_level;
      logic [LEVEL_W-1:0] level_q[$];
      int errors;
      int samples;
      int windows;
      int reg_writes;

      function new();
         noise_floor = NOISE_FLOOR_RST;
         full_scale = FULL_SCALE_RST;
         window_max = '0;
         window_min = SAMPLE_MAX;
         held_level = '0;
         errors = 0;
         samples = 0;
         windows = 0;
         reg_writes = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [SAMPLE_W-1:0] value);
         reg_writes++;
         if (index == REG_NOISE_FLOOR)
            noise_floor = value;
         else if (index == REG_FULL_SCALE)
            full_scale = value;
      endfunction

      function int map_swing(int swing);
         int span;
         int lvl;
         span = int'(full_scale) - int'(noise_floor);
         if (span <= 0)
            return (swing > int'(noise_floor)) ? MAX_LEVEL : 0;
         lvl = ((swing - int'(noise_floor)) * MAX_LEVEL) / span;
         if (lvl > MAX_LEVEL)
            lvl = MAX_LEVEL;
         if (lvl < 0)
            lvl = 0;
         return lvl;
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] sample, logic window_end);
         int swing;
         int lvl;
         samples++;
         if (sample > window_max)
            window_max = sample;
         if (sample < window_min)
            window_min = sample;
         if (!window_end)
            return;
         swing = (window_max >= window_min) ? int'(window_max) - int'(window_min) : 0;
         if (swing < int'(noise_floor))
            swing = 0;
         lvl = map_swing(swing);
         if (lvl >= int'(held_level))
            held_level = LEVEL_W'(lvl);
         else
            held_level = held_level - 1'b1;
         window_max = '0;
         window_min = SAMPLE_MAX;
         windows++;
         level_q.push_back(held_level);
      endfunction

      function void check_level(logic [LEVEL_W-1:0] got);
         logic [LEVEL_W-1:0] want;
         if (level_q.size() == 0) begin
            errors++;
            $display("%0t: level with nothing expected: expected none, actual %0d", $time, got);
         end else begin
            want = level_q.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t: level mismatch: expected %0d, actual %0d", $time, want, got);
            end
         end
      endfunction

      function int pending();
         return level_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;   // [11:0] sample
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;        // [5:0] level
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [SAMPLE_W-1:0]    csr_data = '0;

   level_scoreboard levels = new();
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit long_hold_req = 1'b0;

   audio_peak_level_meter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // check results before noting samples taken on the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            levels.check_level(rsp_tdata[LEVEL_W-1:0]);
         if (req_tvalid && req_tready)
            levels.note_sample(req_tdata[SAMPLE_W-1:0], req_tlast);
         if (csr_valid && csr_ready)
            levels.write_reg(csr_index, csr_data);
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      int hold;
      hold = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold = LONG_HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat for %0d cycles, %0d levels outstanding", $time, quiet,
               levels.pending());
      $display("** audio_peak_level_meter_unit: FAILED **");
      $finish;
   end

   task automatic send_sample(input int sample, input bit window_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - SAMPLE_W){1'b0}}, SAMPLE_W'(sample)};
      req_tlast <= window_end;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic stop_samples();
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
   endtask

   // let the monitor note the last beat before looking at the queue
   task automatic wait_drained();
      stop_samples();
      @(posedge clock);
      while (levels.pending() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= SAMPLE_W'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_range(input int floor_value, input int scale_value);
      wait_drained();
      write_reg(REG_NOISE_FLOOR, floor_value);
      write_reg(REG_FULL_SCALE, scale_value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_windows(input int n_items, input int max_len);
      int left;
      int len;
      int span;
      int lo;
      int r;
      int s;
      bit exact;
      bit broken;
      left = n_items;
      while (left > 0) begin
         r = $urandom_range(99);
         if (r < 70)
            len = $urandom_range(6, 1);
         else if (r < 95)
            len = $urandom_range(30, 7);
         else
            len = $urandom_range(80, 31);
         if (len > max_len)
            len = $urandom_range(max_len, 1);
         if (len > left)
            len = left;
         r = $urandom_range(99);
         if (r < 15)
            span = $urandom_range(300);
         else if (r < 85)
            span = $urandom_range(4095);
         else
            span = 4095;
         lo = $urandom_range(4095 - span);
         exact = $urandom_range(1);
         broken = ($urandom_range(99) < 5);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 8)
               s = $urandom_range(4095);
            else if (exact && k == 0)
               s = lo;
            else if (exact && k == 1)
               s = lo + span;
            else
               s = lo + $urandom_range(span);
            send_sample(s, (k == len - 1) && !broken);
         end
         left -= len;
      end
   endtask

   initial begin
      int nf;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 16;
      rsp_idle_pct = 56;

      // lone sample: swing forced to zero, numerator below zero
      send_sample(2048, 1'b1);
      send_sample(0, 1'b0);
      send_sample(4095, 1'b1);
      // decay one per window
      send_sample(100, 1'b1);
      send_sample(1000, 1'b0);
      send_sample(1149, 1'b1);
      send_sample(1000, 1'b0);
      send_sample(1150, 1'b1);
      send_sample(500, 1'b0);
      send_sample(2850, 1'b1);
      send_sample(0, 1'b0);
      send_sample(2500, 1'b1);
      // window end sample holds an extreme
      send_sample(12'hAAA, 1'b0);
      send_sample(12'h555, 1'b0);
      send_sample(4095, 1'b0);
      send_sample(2047, 1'b0);
      send_sample(0, 1'b1);
      send_sample(3000, 1'b0);
      send_sample(3100, 1'b1);
      send_sample(3000, 1'b1);
      random_windows(350, 80);

      // hold the result side so the block backs up onto the sample side
      long_hold_req = 1'b1;
      random_windows(60, 3);

      set_range(0, 4095);
      send_sample(777, 1'b1);
      send_sample(0, 1'b0);
      send_sample(4095, 1'b1);
      random_windows(150, 80);

      send_idle_pct = 56;
      rsp_idle_pct = 16;

      // map span not positive: level steps between zero and top
      set_range(4094, 1);
      send_sample(0, 1'b0);
      send_sample(4095, 1'b1);
      send_sample(0, 1'b0);
      send_sample(4094, 1'b1);
      send_sample(7, 1'b1);
      random_windows(120, 80);
      set_range(2000, 2000);
      random_windows(100, 80);
      nf = $urandom_range(2000);
      set_range(nf, nf + 1 + $urandom_range(4094 - nf));
      random_windows(150, 80);

      send_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (3) begin
         nf = $urandom_range(4094);
         if ($urandom_range(3) == 0)
            set_range(nf, $urandom_range(4095, 1));
         else
            set_range(nf, nf + 1 + $urandom_range(4094 - nf));
         random_windows(100, 80);
      end

      wait_drained();
      $display("Covered %0d samples and %0d window levels over %0d register writes,",
               levels.samples, levels.windows, levels.reg_writes);
      $display("including degenerate map spans and a long result-side stall.");
      if (levels.errors == 0)
         $display("** audio_peak_level_meter_unit: PASSED **");
      else
         $display("** audio_peak_level_meter_unit: FAILED **");
      $finish;
   end

endmodule
